/* hdl/rrlp_pkg.sv */
package rrlp_pkg;

   // Line handling
   localparam int LINE_LIMIT = 1024;
   localparam int LEN_W      = $clog2(LINE_LIMIT + 2);
   localparam int FIELD_COUNT = 5;
   localparam int SLOT_COUNT  = 3;

   // Field indexes
   localparam logic [2:0] F_FILT   = 3'd0;
   localparam logic [2:0] F_RAW    = 3'd1;
   localparam logic [2:0] F_COUNT  = 3'd2;
   localparam logic [2:0] F_TAG    = 3'd3;
   localparam logic [2:0] F_ANCHOR = 3'd4;

   // Number scan phases
   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_PREFIX = 3'd3;
   localparam logic [2:0] PH_STOP   = 3'd4;

   // Tag section phases
   localparam logic [1:0] TP_SKIP   = 2'd0;
   localparam logic [1:0] TP_TAG    = 2'd1;
   localparam logic [1:0] TP_ANCHOR = 2'd2;
   localparam logic [1:0] TP_DONE   = 2'd3;

   // Line status codes
   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_ACCEPTED = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;
   localparam logic [1:0] ST_OVERLONG = 2'd3;

   // Register indexes and reset values
   localparam logic [1:0]  REG_MAX_DIST   = 2'd0;
   localparam logic [1:0]  REG_MIN_DIST   = 2'd1;
   localparam logic [1:0]  REG_WANTED_TAG = 2'd2;
   localparam logic [23:0] MAX_DIST_RESET = 24'd1000000;
   localparam logic [23:0] MIN_DIST_RESET = 24'd0;
   localparam logic [14:0] TAG_RESET      = 15'd8;

   // Characters
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LC    = 8'h63;
   localparam logic [7:0] CH_LM    = 8'h6D;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   localparam logic [23:0] MAG_CAP = 24'hFFFFFF;

   typedef struct packed {
      logic [23:0] acc;
      logic        neg;
      logic [2:0]  phase;
      logic        one_zero;
   } field_state_type;

   // Clamp a magnitude and sign to a 24-bit two's complement value
   function automatic logic [23:0] clamp_wide(field_state_type f);
      logic [23:0] m;
      begin
         if (f.neg) begin
            m = (f.acc > 24'h800000) ? 24'h800000 : f.acc;
            clamp_wide = 24'd0 - m;
         end else begin
            clamp_wide = (f.acc > 24'h7FFFFF) ? 24'h7FFFFF : f.acc;
         end
      end
   endfunction

   // Clamp a magnitude and sign to a 16-bit two's complement value
   function automatic logic [15:0] clamp_narrow(field_state_type f);
      logic [15:0] m;
      begin
         if (f.neg) begin
            m = (f.acc > 24'h008000) ? 16'h8000 : f.acc[15:0];
            clamp_narrow = 16'd0 - m;
         end else begin
            clamp_narrow = (f.acc > 24'h007FFF) ? 16'h7FFF : f.acc[15:0];
         end
      end
   endfunction

endpackage

/* hdl/rrlp_digit_unit.sv */
module rrlp_digit_unit (
   input  rrlp_pkg::field_state_type cur,
   input  logic [7:0]                byte_value,
   input  logic                      hex_mode,
   output rrlp_pkg::field_state_type nxt
);
   import rrlp_pkg::*;

   logic        is_dec;
   logic        is_lo;
   logic        is_up;
   logic        d_ok;
   logic [3:0]  d_val;
   logic        is_ws;
   logic        is_sign;
   logic        is_x;
   logic [27:0] prod;
   logic [28:0] sum;
   logic [23:0] acc_step;

   // Classify the byte
   assign is_dec  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
   assign is_lo   = (byte_value >= CH_LA) && (byte_value <= CH_LF);
   assign is_up   = (byte_value >= CH_UA) && (byte_value <= CH_UF);
   assign d_ok    = is_dec || (hex_mode && (is_lo || is_up));
   assign is_ws   = (byte_value == CH_SPACE) ||
                    ((byte_value >= CH_TAB) && (byte_value <= CH_CR));
   assign is_sign = (byte_value == CH_PLUS) || (byte_value == CH_MINUS);
   assign is_x    = (byte_value == CH_LX) || (byte_value == CH_UX);

   always_comb begin
      if (is_dec) begin
         d_val = 4'(byte_value - CH_ZERO);
      end else if (is_lo) begin
         d_val = 4'(byte_value - CH_LA + 8'd10);
      end else begin
         d_val = 4'(byte_value - CH_UA + 8'd10);
      end
   end

   // Shift in one digit, saturating at the magnitude cap
   assign prod     = hex_mode ? {cur.acc, 4'b0000}
                              : ({1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0});
   assign sum      = {1'b0, prod} + {25'd0, d_val};
   assign acc_step = (sum[28:24] != 5'd0) ? MAG_CAP : sum[23:0];

   // Advance the scan phase
   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_LEAD, PH_SIGN: begin
            if ((cur.phase == PH_LEAD) && is_ws) begin
               nxt = cur;
            end else if ((cur.phase == PH_LEAD) && is_sign) begin
               nxt.neg   = (byte_value == CH_MINUS);
               nxt.phase = PH_SIGN;
            end else if (d_ok) begin
               nxt.acc      = {20'd0, d_val};
               nxt.one_zero = (d_val == 4'd0);
               nxt.phase    = PH_DIGITS;
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         PH_DIGITS: begin
            if (d_ok) begin
               nxt.acc      = acc_step;
               nxt.one_zero = 1'b0;
            end else if (hex_mode && cur.one_zero && is_x) begin
               nxt.one_zero = 1'b0;
               nxt.phase    = PH_PREFIX;
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         PH_PREFIX: begin
            if (d_ok) begin
               nxt.acc   = {20'd0, d_val};
               nxt.phase = PH_DIGITS;
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

/* hdl/ranging_report_line_parser.sv */
// Channel   | Direction | Handshake            | Payload
// req       | in        | req_valid/req_ready  | req_byte_in, one text byte
// rsp       | out       | rsp_valid/rsp_ready  | line status, parsed fields, ranges, totals
// csr       | in        | csr_we               | csr_index, csr_wdata
//
// One byte per cycle unless stalled: a byte is registered, then parsed into the line state;
// a newline loads the result register in the same parse cycle.
// The byte register only stalls when a newline meets a full, untaken result register.
// Reset is synchronous: clears line state, slots, totals, valid flags; presets CSRs.
// Only newlines produce a transaction on rsp; other bytes produce none.
module ranging_report_line_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_line_status,
   output logic signed [23:0] rsp_filtered_distance,
   output logic signed [23:0] rsp_raw_distance,
   output logic signed [15:0] rsp_sample_count,
   output logic signed [15:0] rsp_tag_id,
   output logic signed [15:0] rsp_anchor_id,
   output logic               rsp_set_complete,
   output logic [23:0]        rsp_range_first,
   output logic [23:0]        rsp_range_second,
   output logic [23:0]        rsp_range_third,
   output logic [31:0]        rsp_accepted_total,
   output logic [31:0]        rsp_overwrite_total,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import rrlp_pkg::*;

   // Configuration
   logic [23:0] max_dist_ff;
   logic [23:0] min_dist_ff;
   logic [14:0] wanted_tag_ff;

   // Byte register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] byte_ff;

   // Line state
   logic [LEN_W-1:0] len_ff, len_in;
   logic [3:0]       space_ff, space_in;
   logic             saw_m_ff, saw_m_in;
   logic             report_ff, report_in;
   logic [1:0]       tag_ph_ff, tag_ph_in;
   field_state_type  field_ff [FIELD_COUNT];
   field_state_type  field_in [FIELD_COUNT];
   logic [23:0]      slot_ff [SLOT_COUNT];
   logic [23:0]      slot_in [SLOT_COUNT];
   logic [23:0]      slot_after [SLOT_COUNT];
   logic [31:0]      acc_cnt_ff, acc_cnt_in;
   logic [31:0]      ovw_cnt_ff, ovw_cnt_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [23:0] fil_ff, raw_ff;
   logic [15:0] cnt_ff, tag_ff, anc_ff;
   logic        complete_ff;
   logic [23:0] r0_ff, r1_ff, r2_ff;
   logic [31:0] acc_out_ff, ovw_out_ff;

   // Datapath
   logic            is_nl;
   logic            advance;
   logic            step;
   logic            push;
   logic            parse_en;
   logic            feed_en;
   logic [2:0]      feed_idx;
   logic            hex_mode;
   field_state_type feed_cur;
   field_state_type feed_nxt;
   logic            overlong;
   logic [23:0]     fil_v, raw_v;
   logic [15:0]     cnt_v, tag_v, anc_v;
   logic            fil_ok, tag_ok, anc_ok, hit;
   logic [1:0]      anc_idx;
   logic            complete;

   assign is_nl     = (byte_ff == CH_NL);
   assign advance   = !(in_valid_ff && is_nl && rsp_valid_ff && !rsp_ready);
   assign step      = in_valid_ff && advance;
   assign push      = step && is_nl;
   assign req_ready = !in_valid_ff || advance;

   // Hold or load the byte register
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_byte_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff   <= MAX_DIST_RESET;
         min_dist_ff   <= MIN_DIST_RESET;
         wanted_tag_ff <= TAG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_DIST:   max_dist_ff   <= csr_wdata;
            REG_MIN_DIST:   min_dist_ff   <= csr_wdata;
            REG_WANTED_TAG: wanted_tag_ff <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Pick the field that this byte feeds
   assign parse_en = !is_nl && (len_ff < LEN_W'(LINE_LIMIT));

   always_comb begin
      feed_en  = 1'b0;
      feed_idx = F_FILT;
      if (space_ff >= 4'd9) begin
         if ((tag_ph_ff == TP_TAG) && (byte_ff != CH_COLON)) begin
            feed_en  = 1'b1;
            feed_idx = F_TAG;
         end else if ((tag_ph_ff == TP_ANCHOR) && (byte_ff != CH_COLON)) begin
            feed_en  = 1'b1;
            feed_idx = F_ANCHOR;
         end
      end else if (byte_ff != CH_SPACE) begin
         case (space_ff)
            4'd2: begin
               feed_en  = 1'b1;
               feed_idx = F_FILT;
            end
            4'd3: begin
               feed_en  = 1'b1;
               feed_idx = F_RAW;
            end
            4'd6: begin
               feed_en  = 1'b1;
               feed_idx = F_COUNT;
            end
            default: begin
               feed_en = 1'b0;
            end
         endcase
      end
   end

   assign hex_mode = (feed_idx == F_FILT) || (feed_idx == F_RAW);
   assign feed_cur = field_ff[feed_idx];

   rrlp_digit_unit u_digit (
      .cur        (feed_cur),
      .byte_value (byte_ff),
      .hex_mode   (hex_mode),
      .nxt        (feed_nxt)
   );

   // Evaluate the finished line
   assign overlong = (len_ff > LEN_W'(LINE_LIMIT));
   assign fil_v    = clamp_wide(field_ff[F_FILT]);
   assign raw_v    = clamp_wide(field_ff[F_RAW]);
   assign cnt_v    = clamp_narrow(field_ff[F_COUNT]);
   assign tag_v    = clamp_narrow(field_ff[F_TAG]);
   assign anc_v    = clamp_narrow(field_ff[F_ANCHOR]);
   assign fil_ok   = !fil_v[23] && (fil_v < max_dist_ff) && (fil_v > min_dist_ff);
   assign tag_ok   = !tag_v[15] && (tag_v[14:0] == wanted_tag_ff);
   assign anc_ok   = (anc_v[15:2] == 14'd0) && (anc_v[1:0] != 2'd3);
   assign anc_idx  = anc_v[1:0];
   assign hit      = report_ff && !overlong && fil_ok && tag_ok && anc_ok;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_after[i] = (hit && (anc_idx == 2'(i))) ? fil_v : slot_ff[i];
      end
   end

   assign complete = hit && (slot_after[0] != 24'd0) && (slot_after[1] != 24'd0) &&
                     (slot_after[2] != 24'd0);

   // Next line state
   always_comb begin
      len_in     = len_ff;
      space_in   = space_ff;
      saw_m_in   = saw_m_ff;
      report_in  = report_ff;
      tag_ph_in  = tag_ph_ff;
      acc_cnt_in = acc_cnt_ff;
      ovw_cnt_in = ovw_cnt_ff;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         field_in[i] = field_ff[i];
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (step && is_nl) begin
         // close the line and update slots and totals
         len_in    = '0;
         space_in  = 4'd0;
         saw_m_in  = 1'b0;
         report_in = 1'b0;
         tag_ph_in = TP_SKIP;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            field_in[i] = '0;
         end
         if (hit) begin
            if (slot_ff[anc_idx] != 24'd0) begin
               ovw_cnt_in = ovw_cnt_ff + 32'd1;
            end else begin
               acc_cnt_in = acc_cnt_ff + 32'd1;
            end
         end
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_in[i] = complete ? 24'd0 : slot_after[i];
         end
      end else if (step) begin
         if (len_ff <= LEN_W'(LINE_LIMIT)) begin
            len_in = len_ff + LEN_W'(1);
         end
         if (parse_en) begin
            if (saw_m_ff && (byte_ff == CH_LC)) begin
               report_in = 1'b1;
            end
            saw_m_in = (byte_ff == CH_LM);
            if (space_ff >= 4'd9) begin
               case (tag_ph_ff)
                  TP_SKIP: tag_ph_in = TP_TAG;
                  TP_TAG: begin
                     if (byte_ff == CH_COLON) begin
                        tag_ph_in = TP_ANCHOR;
                     end
                  end
                  TP_ANCHOR: begin
                     if (byte_ff == CH_COLON) begin
                        tag_ph_in = TP_DONE;
                     end
                  end
                  default: tag_ph_in = tag_ph_ff;
               endcase
            end else if (byte_ff == CH_SPACE) begin
               space_in = space_ff + 4'd1;
            end
            if (feed_en) begin
               field_in[feed_idx] = feed_nxt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         space_ff   <= 4'd0;
         saw_m_ff   <= 1'b0;
         report_ff  <= 1'b0;
         tag_ph_ff  <= TP_SKIP;
         acc_cnt_ff <= 32'd0;
         ovw_cnt_ff <= 32'd0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            field_ff[i] <= '0;
         end
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= 24'd0;
         end
      end else begin
         len_ff     <= len_in;
         space_ff   <= space_in;
         saw_m_ff   <= saw_m_in;
         report_ff  <= report_in;
         tag_ph_ff  <= tag_ph_in;
         acc_cnt_ff <= acc_cnt_in;
         ovw_cnt_ff <= ovw_cnt_in;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            field_ff[i] <= field_in[i];
         end
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // Result register: load on a newline, drop once taken
   always_comb begin
      if (overlong) begin
         status_in = ST_OVERLONG;
      end else if (!report_ff) begin
         status_in = ST_NONE;
      end else if (hit) begin
         status_in = ST_ACCEPTED;
      end else begin
         status_in = ST_REJECTED;
      end
   end

   assign rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (push) begin
         status_ff   <= status_in;
         fil_ff      <= (report_ff && !overlong) ? fil_v : 24'd0;
         raw_ff      <= (report_ff && !overlong) ? raw_v : 24'd0;
         cnt_ff      <= (report_ff && !overlong) ? cnt_v : 16'd0;
         tag_ff      <= (report_ff && !overlong) ? tag_v : 16'd0;
         anc_ff      <= (report_ff && !overlong) ? anc_v : 16'd0;
         complete_ff <= complete;
         r0_ff       <= complete ? slot_after[0] : 24'd0;
         r1_ff       <= complete ? slot_after[1] : 24'd0;
         r2_ff       <= complete ? slot_after[2] : 24'd0;
         acc_out_ff  <= acc_cnt_in;
         ovw_out_ff  <= ovw_cnt_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_line_status       = status_ff;
   assign rsp_filtered_distance = fil_ff;
   assign rsp_raw_distance      = raw_ff;
   assign rsp_sample_count      = cnt_ff;
   assign rsp_tag_id            = tag_ff;
   assign rsp_anchor_id         = anc_ff;
   assign rsp_set_complete      = complete_ff;
   assign rsp_range_first       = r0_ff;
   assign rsp_range_second      = r1_ff;
   assign rsp_range_third       = r2_ff;
   assign rsp_accepted_total    = acc_out_ff;
   assign rsp_overwrite_total   = ovw_out_ff;

`ifndef SYNTHESIS
   a_len_cap : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_LIMIT + 1))
      else $error("line length counter ran past its cap");

   a_space_cap : assert property (@(posedge clock) disable iff (reset)
      space_ff <= 4'd9)
      else $error("space counter ran past the tag section");

   a_slots_clear : assert property (@(posedge clock) disable iff (reset)
      (push && complete) |=>
      (slot_ff[0] == 24'd0 && slot_ff[1] == 24'd0 && slot_ff[2] == 24'd0))
      else $error("slots not cleared after a complete set");

   a_one_count : assert property (@(posedge clock) disable iff (reset)
      (push && hit) |=>
      (32'(acc_cnt_ff + ovw_cnt_ff) == 32'($past(acc_cnt_ff + ovw_cnt_ff) + 32'd1)))
      else $error("accepted report did not bump exactly one total");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(byte_ff)))
      else $error("stalled byte lost from the byte register");
`endif

endmodule
